FILE: sv/assert_macros.svh
// Assertion helpers for the RTL. Clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CET_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Condition that must hold in the cycle after the trigger.
`define CET_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

FILE: sv/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Types, constants and tables shared by the calendar elapsed time unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cet_pkg;

    localparam int ACC_W   = 24;   // signed accumulator, holds day and second sums
    localparam int TERM_W  = 21;   // unsigned term magnitude (365 * year fits)
    localparam int MUL_W   = 13;   // multiplier operand width
    localparam int QUOT_W  = 7;    // quotient of a year-sized value by 100
    localparam int REM_W   = 17;   // seconds of day, below 86400
    localparam int DAYS_W  = 16;
    localparam int HOURS_W = 5;
    localparam int MINS_W  = 6;
    localparam int SECS_W  = 6;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_YEAR = 365;
    localparam int MAX_DAYS      = 65535;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MIN       = 59;
    localparam int MAX_SEC       = 59;

    // floor(x / 100) == (x * RECIP100) >> RECIP_SHIFT, exact for x < 43690
    localparam int RECIP100    = 5243;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Sequencer steps; each one makes at most one term (the floor steps only
    // record a quotient). Order matters: the sequencer walks them by increment.
    typedef enum logic [4:0] {
        STEP_IDLE,
        STEP_HOUR_NOW,
        STEP_MIN_NOW,
        STEP_SEC_NOW,
        STEP_HOUR_START,
        STEP_MIN_START,
        STEP_SEC_START,
        STEP_FLR100_NOW,
        STEP_FLR400_NOW,
        STEP_Y365_NOW,
        STEP_Q4_NOW,
        STEP_CEIL100_NOW,
        STEP_CEIL400_NOW,
        STEP_MONTH_NOW,
        STEP_DAY_NOW,
        STEP_FLR100_START,
        STEP_FLR400_START,
        STEP_Y365_START,
        STEP_Q4_START,
        STEP_CEIL100_START,
        STEP_CEIL400_START,
        STEP_MONTH_START,
        STEP_DAY_START
    } step_t;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_ADD,
        TERM_SUB
    } term_op_t;

    typedef struct packed {
        term_op_t            op;
        logic [TERM_W-1:0]   value;
    } term_t;

    typedef enum logic [1:0] {
        ALU_HOLD,
        ALU_LOAD,
        ALU_SUM
    } alu_op_t;

    typedef enum logic [1:0] {
        ALU_SRC_TERM,
        ALU_SRC_DAY,
        ALU_SRC_HOUR,
        ALU_SRC_MIN
    } alu_src_t;

    typedef struct packed {
        alu_op_t  op;
        alu_src_t src;
        acc_t     load_val;
    } alu_ctl_t;

    typedef struct packed {
        logic acc_neg;
        logic sum_neg;
    } alu_flags_t;

    typedef enum logic [1:0] {
        STATUS_LATER = 2'd0,
        STATUS_EQUAL = 2'd1,
        STATUS_DONE  = 2'd2
    } status_t;

    // Days in a common year before month m; months outside 1..12 count as January.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cet_term_gen.sv
// ----------------------------------------------------------------------------
// cet_term_gen
// Registered term source: one constant multiply per step for hour, minute,
// year and divide-by-100 terms, plus leap year tracking for the month term.
// ----------------------------------------------------------------------------
`default_nettype none

module cet_term_gen (
    input  logic            clk,
    input  logic            rst_n,
    input  cet_pkg::step_t  step,
    input  cet_pkg::stamp_t start_stamp,
    input  cet_pkg::stamp_t now_stamp,
    output cet_pkg::term_t  term
);

    logic                          use_start;
    cet_pkg::stamp_t               st;
    logic [cet_pkg::MUL_W-1:0]     yr;
    logic [cet_pkg::MUL_W-1:0]     mul_a;
    logic [cet_pkg::MUL_W-1:0]     mul_b;
    logic [2*cet_pkg::MUL_W-1:0]   product;
    logic [cet_pkg::QUOT_W-1:0]    quot;
    logic                          use_recip;
    logic                          use_mul;
    logic [cet_pkg::TERM_W-1:0]    direct;
    cet_pkg::term_op_t             add_op;
    cet_pkg::term_op_t             sub_op;
    cet_pkg::term_op_t             op_next;
    logic [cet_pkg::TERM_W-1:0]    value_next;
    logic                          leap;
    logic                          month_late;

    logic [cet_pkg::QUOT_W-1:0]    flr100_reg;
    logic [cet_pkg::QUOT_W-1:0]    ceil100_reg;
    logic [cet_pkg::QUOT_W-1:0]    flr400_reg;
    logic [cet_pkg::QUOT_W-1:0]    ceil400_reg;
    cet_pkg::term_op_t             op_reg;
    logic [cet_pkg::TERM_W-1:0]    value_reg;

    always_comb
    begin
        case (step)
            cet_pkg::STEP_HOUR_START, cet_pkg::STEP_MIN_START, cet_pkg::STEP_SEC_START,
            cet_pkg::STEP_FLR100_START, cet_pkg::STEP_FLR400_START,
            cet_pkg::STEP_Y365_START, cet_pkg::STEP_Q4_START,
            cet_pkg::STEP_CEIL100_START, cet_pkg::STEP_CEIL400_START,
            cet_pkg::STEP_MONTH_START, cet_pkg::STEP_DAY_START:
                use_start = 1'b1;
            default:
                use_start = 1'b0;
        endcase
    end

    assign st     = use_start ? start_stamp : now_stamp;
    assign yr     = cet_pkg::MUL_W'(st.year);
    assign add_op = use_start ? cet_pkg::TERM_SUB : cet_pkg::TERM_ADD;
    assign sub_op = use_start ? cet_pkg::TERM_ADD : cet_pkg::TERM_SUB;

    // leap: divisible by 400, or by 4 and not by 100 (floor == ceil means divisible)
    assign leap       = (flr400_reg == ceil400_reg)
                     || ((st.year[1:0] == 2'b00) && (flr100_reg != ceil100_reg));
    assign month_late = (st.month > 4'd2) && (st.month <= 4'd12);

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        use_recip = 1'b0;
        use_mul   = 1'b0;
        direct    = '0;
        op_next   = cet_pkg::TERM_NONE;
        case (step)
            cet_pkg::STEP_HOUR_NOW, cet_pkg::STEP_HOUR_START:
            begin
                mul_a   = cet_pkg::MUL_W'(cet_pkg::SECS_PER_HOUR);
                mul_b   = cet_pkg::MUL_W'(st.hour);
                use_mul = 1'b1;
                op_next = add_op;
            end
            cet_pkg::STEP_MIN_NOW, cet_pkg::STEP_MIN_START:
            begin
                mul_a   = cet_pkg::MUL_W'(cet_pkg::SECS_PER_MIN);
                mul_b   = cet_pkg::MUL_W'(st.minute);
                use_mul = 1'b1;
                op_next = add_op;
            end
            cet_pkg::STEP_SEC_NOW, cet_pkg::STEP_SEC_START:
            begin
                direct  = cet_pkg::TERM_W'(st.second);
                op_next = add_op;
            end
            cet_pkg::STEP_FLR100_NOW, cet_pkg::STEP_FLR100_START:
            begin
                mul_a     = cet_pkg::MUL_W'(cet_pkg::RECIP100);
                mul_b     = yr;
                use_recip = 1'b1;
            end
            cet_pkg::STEP_FLR400_NOW, cet_pkg::STEP_FLR400_START:
            begin
                mul_a     = cet_pkg::MUL_W'(cet_pkg::RECIP100);
                mul_b     = yr >> 2;
                use_recip = 1'b1;
            end
            cet_pkg::STEP_Y365_NOW, cet_pkg::STEP_Y365_START:
            begin
                mul_a   = cet_pkg::MUL_W'(cet_pkg::DAYS_PER_YEAR);
                mul_b   = yr;
                use_mul = 1'b1;
                op_next = add_op;
            end
            cet_pkg::STEP_Q4_NOW, cet_pkg::STEP_Q4_START:
            begin
                direct  = cet_pkg::TERM_W'((yr + cet_pkg::MUL_W'(3)) >> 2);
                op_next = add_op;
            end
            cet_pkg::STEP_CEIL100_NOW, cet_pkg::STEP_CEIL100_START:
            begin
                mul_a     = cet_pkg::MUL_W'(cet_pkg::RECIP100);
                mul_b     = yr + cet_pkg::MUL_W'(99);
                use_recip = 1'b1;
                op_next   = sub_op;
            end
            cet_pkg::STEP_CEIL400_NOW, cet_pkg::STEP_CEIL400_START:
            begin
                mul_a     = cet_pkg::MUL_W'(cet_pkg::RECIP100);
                mul_b     = (yr + cet_pkg::MUL_W'(399)) >> 2;
                use_recip = 1'b1;
                op_next   = add_op;
            end
            cet_pkg::STEP_MONTH_NOW, cet_pkg::STEP_MONTH_START:
            begin
                direct  = cet_pkg::TERM_W'(cet_pkg::month_start(st.month))
                        + cet_pkg::TERM_W'(month_late && leap);
                op_next = add_op;
            end
            cet_pkg::STEP_DAY_NOW, cet_pkg::STEP_DAY_START:
            begin
                direct  = cet_pkg::TERM_W'(st.day);
                op_next = add_op;
            end
            default:
            begin
                op_next = cet_pkg::TERM_NONE;
            end
        endcase
    end

    assign product = mul_a * mul_b;
    assign quot    = product[cet_pkg::RECIP_SHIFT +: cet_pkg::QUOT_W];

    always_comb
    begin
        if (use_recip)
            value_next = cet_pkg::TERM_W'(quot);
        else if (use_mul)
            value_next = product[cet_pkg::TERM_W-1:0];
        else
            value_next = direct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= cet_pkg::TERM_NONE;
        else
            op_reg <= op_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        case (step)
            cet_pkg::STEP_FLR100_NOW, cet_pkg::STEP_FLR100_START:   flr100_reg  <= quot;
            cet_pkg::STEP_FLR400_NOW, cet_pkg::STEP_FLR400_START:   flr400_reg  <= quot;
            cet_pkg::STEP_CEIL100_NOW, cet_pkg::STEP_CEIL100_START: ceil100_reg <= quot;
            cet_pkg::STEP_CEIL400_NOW, cet_pkg::STEP_CEIL400_START: ceil400_reg <= quot;
            default: ;
        endcase
    end

    assign term.op    = op_reg;
    assign term.value = value_reg;

endmodule

`default_nettype wire

FILE: sv/cet_alu.sv
// ----------------------------------------------------------------------------
// cet_alu
// Shared accumulator with one adder: term accumulation, day normalization
// of the seconds sum and trial subtraction for hours and minutes.
// ----------------------------------------------------------------------------
`default_nettype none

module cet_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  cet_pkg::alu_ctl_t   ctl,
    input  cet_pkg::term_t      term,
    output cet_pkg::acc_t       acc,
    output cet_pkg::alu_flags_t flags
);

    cet_pkg::acc_t acc_reg;
    cet_pkg::acc_t acc_next;
    cet_pkg::acc_t operand;
    cet_pkg::acc_t term_ext;
    cet_pkg::acc_t sum;
    logic          acc_neg;

    assign acc_neg  = acc_reg[cet_pkg::ACC_W-1];
    assign term_ext = cet_pkg::acc_t'(term.value);

    always_comb
    begin
        case (ctl.src)
            cet_pkg::ALU_SRC_TERM:
            begin
                case (term.op)
                    cet_pkg::TERM_ADD: operand = term_ext;
                    cet_pkg::TERM_SUB: operand = -term_ext;
                    default:           operand = '0;
                endcase
            end
            // pull the seconds sum toward 0..86399
            cet_pkg::ALU_SRC_DAY:
                operand = acc_neg ?  cet_pkg::acc_t'(cet_pkg::SECS_PER_DAY)
                                  : -cet_pkg::acc_t'(cet_pkg::SECS_PER_DAY);
            cet_pkg::ALU_SRC_HOUR:
                operand = -cet_pkg::acc_t'(cet_pkg::SECS_PER_HOUR);
            cet_pkg::ALU_SRC_MIN:
                operand = -cet_pkg::acc_t'(cet_pkg::SECS_PER_MIN);
            default:
                operand = '0;
        endcase
    end

    assign sum = acc_reg + operand;

    always_comb
    begin
        case (ctl.op)
            cet_pkg::ALU_LOAD: acc_next = ctl.load_val;
            cet_pkg::ALU_SUM:  acc_next = sum;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc           = acc_reg;
    assign flags.acc_neg = acc_neg;
    assign flags.sum_neg = sum[cet_pkg::ACC_W-1];

endmodule

`default_nettype wire

FILE: sv/calendar_elapsed_time_unit.sv
// ----------------------------------------------------------------------------
// calendar_elapsed_time_unit
// Elapsed days, hours, minutes and seconds between two calendar timestamps.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  item      item_valid / item_stall     start_* and now_* timestamp fields
//  result    result_valid / result_stall status, elapsed_days/hours/minutes/seconds
//
//  One item at a time through a single shared adder: a compare step, then for
//  an elapsed result the seconds-sum, normalize, day-sum and check steps, hour
//  and minute trial steps and an output load; when start is not earlier than
//  now the compare leads straight to the output load.
//  The output register lets a new item start while a result waits under
//  result_stall; the next result then holds in its output step until it frees.
//  Reset clears the sequencer and result_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_elapsed_time_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [11:0] start_year,
    input  logic [3:0]  start_month,
    input  logic [4:0]  start_day,
    input  logic [4:0]  start_hour,
    input  logic [5:0]  start_minute,
    input  logic [5:0]  start_second,
    input  logic [11:0] now_year,
    input  logic [3:0]  now_month,
    input  logic [4:0]  now_day,
    input  logic [4:0]  now_hour,
    input  logic [5:0]  now_minute,
    input  logic [5:0]  now_second,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [15:0] elapsed_days,
    output logic [4:0]  elapsed_hours,
    output logic [5:0]  elapsed_minutes,
    output logic [5:0]  elapsed_seconds
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_SEC,
        S_SEC_END,
        S_NORM,
        S_DAY,
        S_DAY_END,
        S_CHK,
        S_HRS,
        S_MINS,
        S_FIN
    } state_t;

    state_t                         state_reg;
    cet_pkg::step_t                 step_reg;
    cet_pkg::stamp_t                start_reg;
    cet_pkg::stamp_t                now_reg;
    logic signed [2:0]              k_reg;       // whole days carried out of the seconds sum
    logic [cet_pkg::REM_W-1:0]      rem_reg;

    cet_pkg::status_t               res_status_reg;
    logic [cet_pkg::DAYS_W-1:0]     res_days_reg;
    logic [cet_pkg::HOURS_W-1:0]    res_hours_reg;
    logic [cet_pkg::MINS_W-1:0]     res_mins_reg;
    logic [cet_pkg::SECS_W-1:0]     res_secs_reg;

    logic                           out_valid_reg;
    cet_pkg::status_t               out_status_reg;
    logic [cet_pkg::DAYS_W-1:0]     out_days_reg;
    logic [cet_pkg::HOURS_W-1:0]    out_hours_reg;
    logic [cet_pkg::MINS_W-1:0]     out_mins_reg;
    logic [cet_pkg::SECS_W-1:0]     out_secs_reg;

    cet_pkg::term_t                 term;
    cet_pkg::alu_ctl_t              alu_ctl;
    cet_pkg::acc_t                  acc;
    cet_pkg::alu_flags_t            flags;
    logic                           norm_step;
    logic                           trial_ok;
    logic                           days_over;
    logic                           out_free;

    cet_term_gen u_term_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step_reg),
        .start_stamp (start_reg),
        .now_stamp   (now_reg),
        .term        (term)
    );

    cet_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .term  (term),
        .acc   (acc),
        .flags (flags)
    );

    assign norm_step = flags.acc_neg || !flags.sum_neg;
    assign trial_ok  = !flags.sum_neg;
    assign days_over = !flags.acc_neg && (acc[cet_pkg::ACC_W-2:cet_pkg::DAYS_W] != '0);
    assign out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        alu_ctl.op       = cet_pkg::ALU_HOLD;
        alu_ctl.src      = cet_pkg::ALU_SRC_TERM;
        alu_ctl.load_val = '0;
        case (state_reg)
            S_CMP:
                alu_ctl.op = cet_pkg::ALU_LOAD;
            S_SEC, S_SEC_END, S_DAY, S_DAY_END:
                alu_ctl.op = cet_pkg::ALU_SUM;
            S_NORM:
            begin
                alu_ctl.src = cet_pkg::ALU_SRC_DAY;
                if (norm_step)
                    alu_ctl.op = cet_pkg::ALU_SUM;
                else
                begin
                    // seconds settled: day sum starts from the carry
                    alu_ctl.op       = cet_pkg::ALU_LOAD;
                    alu_ctl.load_val = cet_pkg::acc_t'(k_reg);
                end
            end
            S_CHK:
            begin
                alu_ctl.op       = cet_pkg::ALU_LOAD;
                alu_ctl.load_val = cet_pkg::acc_t'(rem_reg);
            end
            S_HRS:
            begin
                alu_ctl.src = cet_pkg::ALU_SRC_HOUR;
                if (trial_ok)
                    alu_ctl.op = cet_pkg::ALU_SUM;
            end
            S_MINS:
            begin
                alu_ctl.src = cet_pkg::ALU_SRC_MIN;
                if (trial_ok)
                    alu_ctl.op = cet_pkg::ALU_SUM;
            end
            default:
                alu_ctl.op = cet_pkg::ALU_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= cet_pkg::STEP_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        start_reg <= '{start_year, start_month, start_day,
                                       start_hour, start_minute, start_second};
                        now_reg   <= '{now_year, now_month, now_day,
                                       now_hour, now_minute, now_second};
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    res_days_reg  <= '0;
                    res_hours_reg <= '0;
                    res_mins_reg  <= '0;
                    res_secs_reg  <= '0;
                    k_reg         <= '0;
                    // packed stamps compare year first, second last
                    if (start_reg > now_reg)
                    begin
                        res_status_reg <= cet_pkg::STATUS_LATER;
                        state_reg      <= S_FIN;
                    end
                    else if (start_reg == now_reg)
                    begin
                        res_status_reg <= cet_pkg::STATUS_EQUAL;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        res_status_reg <= cet_pkg::STATUS_DONE;
                        step_reg       <= cet_pkg::STEP_HOUR_NOW;
                        state_reg      <= S_SEC;
                    end
                end
                S_SEC:
                begin
                    if (step_reg == cet_pkg::STEP_SEC_START)
                    begin
                        step_reg  <= cet_pkg::STEP_IDLE;
                        state_reg <= S_SEC_END;
                    end
                    else
                        step_reg <= cet_pkg::step_t'(step_reg + 5'd1);
                end
                S_SEC_END:
                    state_reg <= S_NORM;
                S_NORM:
                begin
                    if (flags.acc_neg)
                        k_reg <= k_reg - 3'sd1;
                    else if (!flags.sum_neg)
                        k_reg <= k_reg + 3'sd1;
                    else
                    begin
                        rem_reg   <= acc[cet_pkg::REM_W-1:0];
                        step_reg  <= cet_pkg::STEP_FLR100_NOW;
                        state_reg <= S_DAY;
                    end
                end
                S_DAY:
                begin
                    if (step_reg == cet_pkg::STEP_DAY_START)
                    begin
                        step_reg  <= cet_pkg::STEP_IDLE;
                        state_reg <= S_DAY_END;
                    end
                    else
                        step_reg <= cet_pkg::step_t'(step_reg + 5'd1);
                end
                S_DAY_END:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    if (flags.acc_neg)
                        state_reg <= S_FIN;
                    else if (days_over)
                    begin
                        res_days_reg  <= cet_pkg::DAYS_W'(cet_pkg::MAX_DAYS);
                        res_hours_reg <= cet_pkg::HOURS_W'(cet_pkg::MAX_HOUR);
                        res_mins_reg  <= cet_pkg::MINS_W'(cet_pkg::MAX_MIN);
                        res_secs_reg  <= cet_pkg::SECS_W'(cet_pkg::MAX_SEC);
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        res_days_reg <= acc[cet_pkg::DAYS_W-1:0];
                        state_reg    <= S_HRS;
                    end
                end
                S_HRS:
                begin
                    if (trial_ok)
                        res_hours_reg <= res_hours_reg + cet_pkg::HOURS_W'(1);
                    else
                        state_reg <= S_MINS;
                end
                S_MINS:
                begin
                    if (trial_ok)
                        res_mins_reg <= res_mins_reg + cet_pkg::MINS_W'(1);
                    else
                    begin
                        res_secs_reg <= acc[cet_pkg::SECS_W-1:0];
                        state_reg    <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_days_reg   <= res_days_reg;
                        out_hours_reg  <= res_hours_reg;
                        out_mins_reg   <= res_mins_reg;
                        out_secs_reg   <= res_secs_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign item_stall      = (state_reg != S_IDLE);
    assign result_valid    = out_valid_reg;
    assign status          = out_status_reg;
    assign elapsed_days    = out_days_reg;
    assign elapsed_hours   = out_hours_reg;
    assign elapsed_minutes = out_mins_reg;
    assign elapsed_seconds = out_secs_reg;

    `CET_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
    `CET_ASSERT_ALWAYS(a_zero_unless_done, !out_valid_reg || out_status_reg == cet_pkg::STATUS_DONE || (out_days_reg == '0 && out_hours_reg == '0 && out_mins_reg == '0 && out_secs_reg == '0))
    `CET_ASSERT_ALWAYS(a_time_in_range, !out_valid_reg || (out_hours_reg <= cet_pkg::HOURS_W'(cet_pkg::MAX_HOUR) && out_mins_reg <= cet_pkg::MINS_W'(cet_pkg::MAX_MIN) && out_secs_reg <= cet_pkg::SECS_W'(cet_pkg::MAX_SEC)))
    `CET_ASSERT_ALWAYS(a_carry_range, k_reg >= -3'sd2 && k_reg <= 3'sd1)

endmodule

`default_nettype wire
